// File: hw/rtl/lgds_pkg.sv
// Package with shared constants for the dictionary search block.
package lgds_pkg;
    localparam int MaxEntries = 1024;
    localparam int TextBytes  = 65536;
    localparam int MaxLen     = 256;

    localparam logic [1:0] ModeText    = 2'd0;
    localparam logic [1:0] ModeEntry   = 2'd1;
    localparam logic [1:0] ModePattern = 2'd2;
    localparam logic [1:0] ModeUnused  = 2'd3;

    localparam logic [1:0] RegEntryCount = 2'd0;

    localparam logic [10:0] CountMin = 11'd2;
endpackage

// File: hw/rtl/lgds_if.sv
// Valid/ready channel interfaces for the search block.
interface lgds_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [15:0] start_offset;
    logic [7:0]  lcp_value;
    logic        last;
    modport source (output valid, mode, address, data_byte, start_offset, lcp_value, last,
                    input ready);
    modport sink   (input valid, mode, address, data_byte, start_offset, lcp_value, last,
                    output ready);
endinterface

interface lgds_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] entry_index;
    logic        found;
    logic        too_long;
    modport source (output valid, entry_index, found, too_long, input ready);
    modport sink   (input valid, entry_index, found, too_long, output ready);
endinterface

// File: hw/rtl/lgds_search.sv
// Memories of the dictionary and the sequencer that runs the binary search.
module lgds_search #(
    parameter int MAX_ENTRIES = lgds_pkg::MaxEntries,
    parameter int TEXT_BYTES  = lgds_pkg::TextBytes,
    parameter int MAX_LEN     = lgds_pkg::MaxLen
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [10:0] i_entry_count,
    lgds_in_if.sink     in_ch,
    lgds_out_if.source  out_ch
);
    localparam int TW = $clog2(TEXT_BYTES);
    localparam int EW = $clog2(MAX_ENTRIES + 1);
    localparam int MW = $clog2(MAX_ENTRIES);
    localparam int PW = $clog2(MAX_LEN);
    localparam int LW = PW + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_MID, S_LCP, S_CMP_RD, S_CMP, S_DONE
    } t_state;

    logic [7:0]  text_mem  [TEXT_BYTES];
    logic [15:0] start_mem [MAX_ENTRIES + 1];
    logic [7:0]  lcp_mem   [MAX_ENTRIES];
    logic [7:0]  pat_mem   [MAX_LEN];

    t_state      r_state;
    logic [LW-1:0] r_plen;
    logic        r_ovf;
    logic [EW-1:0] r_lo, r_hi, r_m;
    logic        r_hit;
    logic [15:0] r_p, r_p0, r_limit, r_base;
    logic [15:0] r_rl;
    logic        r_phase;
    logic [7:0]  r_lcp_rd, r_text_rd, r_pat_rd;
    logic [15:0] r_st0, r_st1;
    logic        r_pat_ok;
    logic        r_out_valid;
    logic [10:0] r_out_idx;
    logic        r_out_found, r_out_long;

    logic acc;
    logic out_free;
    assign in_ch.ready = (r_state == S_IDLE);
    assign acc = in_ch.valid && in_ch.ready;
    assign out_free = !r_out_valid || out_ch.ready;

    // Write ports.
    always_ff @(posedge i_clk) begin
        if (acc && in_ch.mode == lgds_pkg::ModeText)
            text_mem[in_ch.address[TW-1:0]] <= in_ch.data_byte;
        if (acc && in_ch.mode == lgds_pkg::ModeEntry) begin
            if ({16'd0, in_ch.address} <= 32'(MAX_ENTRIES))
                start_mem[in_ch.address[EW-1:0]] <= in_ch.start_offset;
            if ({16'd0, in_ch.address} < 32'(MAX_ENTRIES))
                lcp_mem[in_ch.address[MW-1:0]] <= in_ch.lcp_value;
        end
        if (acc && in_ch.mode == lgds_pkg::ModePattern && r_plen < LW'(MAX_LEN))
            pat_mem[r_plen[PW-1:0]] <= in_ch.data_byte;
    end

    // Read ports, addressed from the sequencer registers.
    logic [TW-1:0] text_addr;
    assign text_addr = TW'(32'(r_base) + 32'(r_p) - 32'(r_p0));
    always_ff @(posedge i_clk) begin
        r_lcp_rd  <= lcp_mem[r_m[MW-1:0]];
        r_st0     <= start_mem[r_m];
        r_st1     <= start_mem[EW'(r_m + 1'b1)];
        r_text_rd <= text_mem[text_addr];
        r_pat_rd  <= pat_mem[r_p[PW-1:0]];
        r_pat_ok  <= (32'(r_p) < 32'(r_plen));
    end

    logic [7:0] pc;
    assign pc = r_pat_ok ? r_pat_rd : 8'd0;
    logic [EW-1:0] mid;
    assign mid = EW'((32'(r_lo) + 32'(r_hi)) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plen <= '0;
            r_ovf <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            // The result register is reloaded in S_DONE, so it is only drained elsewhere.
            if (r_state != S_DONE && out_ch.ready && r_out_valid) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc && in_ch.mode == lgds_pkg::ModePattern) begin
                        if (r_plen < LW'(MAX_LEN)) r_plen <= r_plen + 1'b1;
                        else r_ovf <= 1'b1;
                        if (in_ch.last) begin
                            r_lo <= '0;
                            r_hi <= EW'(i_entry_count - 11'd1);
                            r_rl <= '0;
                            r_hit <= 1'b0;
                            r_state <= S_MID;
                        end
                    end
                end
                S_MID: begin
                    r_m <= mid;
                    r_phase <= 1'b0;
                    r_state <= S_LCP;
                end
                S_LCP: begin
                    // The first phase waits for the table reads to be registered.
                    if (!r_phase) r_phase <= 1'b1;
                    else if ({8'd0, r_lcp_rd} > r_rl) begin
                        if (r_m == r_lo) r_state <= S_DONE;
                        else begin r_hi <= r_m; r_state <= S_MID; end
                    end else if ({8'd0, r_lcp_rd} < r_rl) begin
                        if (r_m == r_lo) r_state <= S_DONE;
                        else begin r_lo <= r_m; r_state <= S_MID; end
                    end else begin
                        r_p <= r_rl;
                        r_p0 <= r_rl;
                        r_base <= r_st0;
                        r_limit <= r_rl + (r_st1 - r_st0);
                        r_state <= S_CMP_RD;
                    end
                end
                S_CMP_RD: r_state <= S_CMP;
                S_CMP: begin
                    if (r_p != r_limit && pc != 8'd0 && r_text_rd != 8'd0
                        && pc == r_text_rd) begin
                        r_p <= r_p + 16'd1;
                        r_state <= S_CMP_RD;
                    end else begin
                        // Compare outcome: equal, pattern greater, or smaller.
                        logic eq, gt;
                        eq = (r_p == r_limit) ? (pc == 8'd0) : (pc == r_text_rd);
                        gt = (r_p == r_limit) ? (pc != 8'd0) : (pc > r_text_rd);
                        if (eq) begin
                            r_lo <= r_m;
                            r_hit <= 1'b1;
                            r_state <= S_DONE;
                        end else if (r_m == r_lo) r_state <= S_DONE;
                        else if (gt) begin r_lo <= r_m; r_state <= S_MID; end
                        else begin r_hi <= r_m; r_rl <= r_p; r_state <= S_MID; end
                    end
                end
                S_DONE: begin
                    // Hold the finished search until the result register is free.
                    if (out_free) begin
                        r_out_idx <= 11'(r_lo);
                        r_out_found <= r_hit;
                        r_out_long <= r_ovf;
                        r_out_valid <= 1'b1;
                        r_plen <= '0;
                        r_ovf <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid       = r_out_valid;
    assign out_ch.entry_index = r_out_idx;
    assign out_ch.found       = r_out_found;
    assign out_ch.too_long    = r_out_long;
endmodule

// File: hw/rtl/lcp_guided_dictionary_search_top.sv
// Top level: APB register for the entry count and the search core.
// Load items and pattern bytes are taken while the core is idle. The last pattern byte
// starts a search that per midpoint latches it, reads the tables and compares LCPs,
// then compares suffix bytes, and ends by loading the output register. Input is held
// off during the search and while a finished search waits for the output register to drain.
// Reset (synchronous, active low) clears the entry count to 2, the pattern
// length and overflow flag; memory contents stay undefined until written.
module lcp_guided_dictionary_search_top #(
    parameter int MAX_ENTRIES = lgds_pkg::MaxEntries,
    parameter int TEXT_BYTES  = lgds_pkg::TextBytes,
    parameter int MAX_LEN     = lgds_pkg::MaxLen
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lgds_in_if.sink     in_ch,
    lgds_out_if.source  out_ch
);
    logic [10:0] r_count;
    logic [10:0] wv;
    assign pready = 1'b1;
    assign wv = pwdata[10:0];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= lgds_pkg::CountMin;
        else if (psel && penable && pwrite && paddr == lgds_pkg::RegEntryCount) begin
            if (wv < lgds_pkg::CountMin) r_count <= lgds_pkg::CountMin;
            else if (32'(wv) > 32'(MAX_ENTRIES)) r_count <= 11'(MAX_ENTRIES);
            else r_count <= wv;
        end
    end
    assign prdata = (paddr == lgds_pkg::RegEntryCount) ? {21'd0, r_count} : 32'd0;

    lgds_search #(.MAX_ENTRIES(MAX_ENTRIES), .TEXT_BYTES(TEXT_BYTES), .MAX_LEN(MAX_LEN))
    u_search (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_entry_count(r_count),
        .in_ch(in_ch), .out_ch(out_ch)
    );
endmodule

// File: dv/testbench.sv
// Self-checking testbench for the LCP-guided dictionary search block.
`timescale 1ns / 1ps

module testbench;
    localparam int IdleLimit  = 20000;
    localparam int SettleWait = 20;
    localparam int RandItems  = 650;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic [15:0] start_offset;
        logic [7:0]  lcp_value;
        logic        last;
    } t_load_item;

    typedef struct {
        logic [10:0] entry_index;
        logic        found;
        logic        too_long;
    } t_search_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lgds_in_if  in_ch ();
    lgds_out_if out_ch ();

    lcp_guided_dictionary_search_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    // Shadow copy of the block's stores and register.
    logic [7:0]  text_mem  [lgds_pkg::TextBytes];
    logic [15:0] start_mem [lgds_pkg::MaxEntries + 1];
    logic [7:0]  lcp_mem   [lgds_pkg::MaxEntries];
    logic [7:0]  pat_buf   [lgds_pkg::MaxLen];
    int unsigned pat_len;
    bit          pat_overflow;
    int unsigned entry_cnt;

    t_search_res pending_results[$];
    logic [7:0]  pat_q[$];
    int          error_cnt;
    int          items_sent;
    bit          idle_on;
    bit          hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pat_byte(int unsigned p);
        if (p < pat_len && p < lgds_pkg::MaxLen) return pat_buf[p];
        return 0;
    endfunction

    function automatic int compare_suffix(int unsigned m, inout int unsigned pos);
        int unsigned p0;
        int unsigned p;
        int unsigned base;
        int unsigned limit;
        logic [15:0] slen;
        int          pc;
        int          tc;
        p0 = pos;
        p = p0;
        base = start_mem[m];
        slen = start_mem[m + 1] - start_mem[m];
        limit = slen + p0;
        while (p < limit) begin
            pc = pat_byte(p);
            tc = text_mem[(base + p - p0) % lgds_pkg::TextBytes];
            if (pc == 0 || tc == 0 || pc != tc) break;
            p++;
        end
        pos = p;
        if (p == limit) return pat_byte(p);
        return pat_byte(p) - int'(text_mem[(base + p - p0) % lgds_pkg::TextBytes]);
    endfunction

    function automatic t_search_res dict_search();
        t_search_res r;
        int unsigned lo;
        int unsigned hi;
        int unsigned rl;
        int unsigned m;
        int unsigned sl;
        int unsigned p;
        int          c;
        lo = 0;
        hi = entry_cnt - 1;
        rl = 0;
        r.found = 1'b0;
        r.too_long = pat_overflow;
        forever begin
            m = (lo + hi) / 2;
            sl = lcp_mem[m];
            if (sl > rl) begin
                if (m == lo) break;
                hi = m;
            end else if (sl == rl) begin
                p = rl;
                c = compare_suffix(m, p);
                if (c == 0) begin
                    r.entry_index = 11'(m);
                    r.found = 1'b1;
                    return r;
                end
                if (m == lo) break;
                if (c > 0) begin
                    lo = m;
                end else begin
                    hi = m;
                    rl = p;
                end
            end else begin
                if (m == lo) break;
                lo = m;
            end
        end
        r.entry_index = 11'(lo);
        return r;
    endfunction

    function automatic void predict_item(t_load_item it);
        case (it.mode)
            lgds_pkg::ModeText: text_mem[it.address] = it.data_byte;
            lgds_pkg::ModeEntry: begin
                if (it.address <= lgds_pkg::MaxEntries) start_mem[it.address] = it.start_offset;
                if (it.address < lgds_pkg::MaxEntries) lcp_mem[it.address] = it.lcp_value;
            end
            lgds_pkg::ModePattern: begin
                if (pat_len < lgds_pkg::MaxLen) begin
                    pat_buf[pat_len] = it.data_byte;
                    pat_len++;
                end else begin
                    pat_overflow = 1'b1;
                end
                if (it.last) begin
                    pending_results.push_back(dict_search());
                    pat_len = 0;
                    pat_overflow = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_cnt++;
    endtask

    task automatic send_item(input t_load_item it);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= it.mode;
        in_ch.address      <= it.address;
        in_ch.data_byte    <= it.data_byte;
        in_ch.start_offset <= it.start_offset;
        in_ch.lcp_value    <= it.lcp_value;
        in_ch.last         <= it.last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_item(it);
        items_sent++;
    endtask

    function automatic t_load_item noise_fields(logic [1:0] mode);
        t_load_item it;
        it.mode = mode;
        it.address = 16'($urandom);
        it.data_byte = 8'($urandom);
        it.start_offset = 16'($urandom);
        it.lcp_value = 8'($urandom);
        it.last = 1'($urandom);
        return it;
    endfunction

    task automatic send_text(input logic [15:0] addr, input logic [7:0] b);
        t_load_item it;
        it = noise_fields(lgds_pkg::ModeText);
        it.address = addr;
        it.data_byte = b;
        send_item(it);
    endtask

    task automatic send_entry(input logic [15:0] idx, input logic [15:0] so,
                              input logic [7:0] lcp);
        t_load_item it;
        it = noise_fields(lgds_pkg::ModeEntry);
        it.address = idx;
        it.start_offset = so;
        it.lcp_value = lcp;
        send_item(it);
    endtask

    // Sends the bytes in pat_q; the final one carries last.
    task automatic send_pattern();
        t_load_item it;
        foreach (pat_q[k]) begin
            it = noise_fields(lgds_pkg::ModePattern);
            it.data_byte = pat_q[k];
            it.last = (k == pat_q.size() - 1);
            send_item(it);
        end
    endtask

    // Ignored or harmless items: unused mode, out-of-range entries, stray text.
    task automatic send_noise();
        t_load_item it;
        case ($urandom_range(0, 2))
            0: it = noise_fields(lgds_pkg::ModeUnused);
            1: begin
                it = noise_fields(lgds_pkg::ModeEntry);
                it.address = 16'($urandom_range(lgds_pkg::MaxEntries + 1, 65535));
            end
            default: it = noise_fields(lgds_pkg::ModeText);
        endcase
        send_item(it);
    endtask

    task automatic wait_results_idle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleWait) @(posedge i_clk);
    endtask

    task automatic write_entry_count(input logic [31:0] value);
        logic [10:0] v;
        in_ch.valid <= 1'b0;
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= lgds_pkg::RegEntryCount;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        v = value[10:0];
        entry_cnt = (v < lgds_pkg::CountMin) ? lgds_pkg::CountMin :
                    (v > lgds_pkg::MaxEntries) ? lgds_pkg::MaxEntries : v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[10:0] != entry_cnt[10:0])
            report($sformatf("entry_count read %0d, want %0d", prdata[10:0], entry_cnt));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random text byte; mostly a tiny alphabet so that comparisons run deep.
    function automatic logic [7:0] dict_byte();
        case ($urandom_range(0, 19))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(1, 3));
        endcase
    endfunction

    // Loads n entries with contiguous stored suffixes at a random text base.
    task automatic load_dictionary(input int n, input int max_len);
        logic [15:0] pos;
        int          len;
        pos = 16'($urandom);
        for (int i = 0; i < n; i++) begin
            send_entry(16'(i), pos,
                       ($urandom_range(0, 9) < 6) ? 8'd0 : 8'($urandom_range(0, 3)));
            len = $urandom_range(0, max_len);
            for (int j = 0; j < len; j++) begin
                send_text(pos, dict_byte());
                pos++;
            end
        end
    endtask

    // Builds a pattern, often from the suffix of an entry in 0 .. kmax.
    task automatic build_pattern(input int kmax);
        int          k;
        int          len;
        logic [15:0] base;
        logic [15:0] slen;
        pat_q.delete();
        if ($urandom_range(0, 1) == 1) begin
            k = $urandom_range(0, kmax);
            base = start_mem[k];
            slen = start_mem[k + 1] - start_mem[k];
            for (int j = 0; j < slen; j++) pat_q.push_back(text_mem[16'(base + j)]);
            if ($urandom_range(0, 3) == 0 && pat_q.size() > 1) void'(pat_q.pop_back());
            if ($urandom_range(0, 3) == 0) pat_q.push_back(8'($urandom_range(1, 3)));
        end
        if (pat_q.size() == 0) begin
            len = $urandom_range(1, 6);
            repeat (len) pat_q.push_back(dict_byte());
        end
    endtask

    task automatic test_directed_small();
        load_dictionary(4, 3);
        send_entry(lgds_pkg::MaxEntries, 16'hFFFF, 8'hFF);
        send_entry(16'hFFFF, 16'h0000, 8'h00);
        send_item(noise_fields(lgds_pkg::ModeUnused));
        send_text(16'hFFFF, 8'hFF);
        wait_results_idle();
        write_entry_count(32'd0);
        pat_q = '{8'd1};
        send_pattern();
        wait_results_idle();
        write_entry_count(32'd1);
        pat_q = '{8'd0, 8'd255};
        send_pattern();
        wait_results_idle();
        write_entry_count(32'd4);
        for (int i = 0; i < 6; i++) begin
            build_pattern(entry_cnt - 2);
            send_pattern();
        end
        pat_q = '{8'd255, 8'd0, 8'd1};
        send_pattern();
        wait_results_idle();
    endtask

    task automatic test_long_patterns();
        load_dictionary(6, 4);
        wait_results_idle();
        write_entry_count(32'd6);
        foreach (pat_q[k]) pat_q[k] = 0;
        pat_q.delete();
        repeat (lgds_pkg::MaxLen) pat_q.push_back(8'($urandom_range(1, 3)));
        send_pattern();
        pat_q.delete();
        repeat (lgds_pkg::MaxLen + 44) pat_q.push_back(8'($urandom_range(1, 3)));
        send_pattern();
        build_pattern(entry_cnt - 2);
        send_pattern();
        wait_results_idle();
    endtask

    // Entry count clamps to the table size; the far midpoints carry a right-LCP
    // above zero, so every search walks left into the low loaded entries.
    task automatic test_full_table();
        idle_on = 1'b0;
        load_dictionary(17, 3);
        for (int k = 5; k <= 9; k++) send_entry(16'((1 << k) - 1), 16'h1234, 8'd1);
        wait_results_idle();
        write_entry_count(32'hFFFF_FFFF);
        idle_on = 1'b1;
        repeat (12) begin
            build_pattern(15);
            send_pattern();
        end
        wait_results_idle();
    endtask

    task automatic test_backpressure();
        load_dictionary(8, 4);
        wait_results_idle();
        write_entry_count(32'd8);
        idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (10) begin
            build_pattern(entry_cnt - 2);
            send_pattern();
        end
        idle_on = 1'b1;
        wait_results_idle();
    endtask

    task automatic test_random();
        int n;
        int goal;
        goal = items_sent + RandItems;
        while (items_sent < goal) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : $urandom_range(4, 24);
            idle_on = ($urandom_range(0, 3) != 0);
            load_dictionary(n, 5);
            wait_results_idle();
            write_entry_count(n);
            repeat (15) begin
                build_pattern(entry_cnt - 2);
                send_pattern();
                if ($urandom_range(0, 4) == 0) send_noise();
            end
            wait_results_idle();
        end
    endtask

    // Result checker and receiver stall generator.
    initial begin
        int          stall;
        int          holding;
        t_search_res want;
        out_ch.ready <= 1'b0;
        stall = 0;
        holding = 0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report("result with no expected transaction");
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.entry_index != want.entry_index)
                        report($sformatf("entry_index %0d, want %0d",
                                         out_ch.entry_index, want.entry_index));
                    if (out_ch.found != want.found)
                        report($sformatf("found %0b, want %0b", out_ch.found, want.found));
                    if (out_ch.too_long != want.too_long)
                        report($sformatf("too_long %0b, want %0b",
                                         out_ch.too_long, want.too_long));
                end
                stall = idle_on ? $urandom_range(0, 10) : 0;
            end
            if (hold_req && holding == 0) begin
                holding = 300;
                hold_req = 1'b0;
            end
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (holding > 0) begin
                holding--;
                out_ch.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Ends the run when no transaction moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel || !i_rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= IdleLimit) begin
                $display("FAIL lcp_guided_dictionary_search_top");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= lgds_pkg::RegEntryCount;
        pwdata <= 32'd0;
        in_ch.valid <= 1'b0;
        in_ch.mode <= lgds_pkg::ModeText;
        in_ch.address <= 16'd0;
        in_ch.data_byte <= 8'd0;
        in_ch.start_offset <= 16'd0;
        in_ch.lcp_value <= 8'd0;
        in_ch.last <= 1'b0;
        pat_len = 0;
        pat_overflow = 1'b0;
        entry_cnt = lgds_pkg::CountMin;
        error_cnt = 0;
        items_sent = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_small();
        test_long_patterns();
        test_full_table();
        test_backpressure();
        test_random();

        wait_results_idle();
        if (error_cnt == 0)
            $display("PASS lcp_guided_dictionary_search_top");
        else
            $display("FAIL lcp_guided_dictionary_search_top");
        $finish;
    end
endmodule
